>>> sv/rdw_pkg.sv
// ============================================================================
// rdw_pkg
// Shared types, codes and defaults of the reliable datagram window engine.
// ============================================================================
`default_nettype none

package rdw_pkg;

   // Default window depths.
   localparam int SEND_DEPTH_DEF = 16;
   localparam int RECV_DEPTH_DEF = 16;

   // Operation codes of an input transaction.
   localparam logic [3:0] OP_OPEN       = 4'd0;
   localparam logic [3:0] OP_SEND_REL   = 4'd1;
   localparam logic [3:0] OP_SEND_PLAIN = 4'd2;
   localparam logic [3:0] OP_ACK_IN     = 4'd3;
   localparam logic [3:0] OP_DATA_REL   = 4'd4;
   localparam logic [3:0] OP_DATA_PLAIN = 4'd5;
   localparam logic [3:0] OP_TAKE       = 4'd6;
   localparam logic [3:0] OP_TICK       = 4'd7;
   localparam logic [3:0] OP_SET_TMO    = 4'd8;
   localparam logic [3:0] OP_SET_CLOSE  = 4'd9;

   // Result kinds.
   localparam logic [2:0] K_NONE    = 3'd0;
   localparam logic [2:0] K_TX      = 3'd1;
   localparam logic [2:0] K_ACK     = 3'd2;
   localparam logic [2:0] K_DELIVER = 3'd3;
   localparam logic [2:0] K_RELEASE = 3'd4;
   localparam logic [2:0] K_RETX    = 3'd5;

   // Connection status codes.
   localparam logic [2:0] ST_INVALID  = 3'd0;
   localparam logic [2:0] ST_ESTAB    = 3'd1;
   localparam logic [2:0] ST_TIMEOUT  = 3'd2;
   localparam logic [2:0] ST_CLOSING  = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;
   localparam logic [2:0] ST_DISABLED = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WINDOW_LIMIT = 2'd0;
   localparam logic [1:0] CSR_RETX_IVAL    = 2'd1;
   localparam logic [1:0] CSR_RETRY_LIMIT  = 2'd2;

   // Configuration reset values.
   localparam logic [4:0]  WINDOW_LIMIT_RST = 5'd16;
   localparam logic [15:0] RETX_IVAL_RST    = 16'd100;
   localparam logic [15:0] RETRY_LIMIT_RST  = 16'd100;

   // Configuration handed to the engine.
   typedef struct packed {
      logic [4:0]  window_limit;
      logic [15:0] retrans_interval;
      logic [15:0] retry_limit;
   } cfg_type;

   // One slot of the send window memory.
   typedef struct packed {
      logic [31:0] id;
      logic [15:0] handle;
      logic [31:0] deadline;
      logic [15:0] retries;
   } send_entry_type;

endpackage

`default_nettype wire

>>> sv/reliable_datagram_window.sv
// ============================================================================
// reliable_datagram_window
// Connection engine for reliable datagrams with a sliding send window,
// cumulative acks and an in-order receive window.
// ============================================================================
// Usage:
// Operations enter on the req_ channel (op, packet_id, handle) and each one
// produces one or more result transactions on the rsp_ channel; rsp_last marks
// the final one, and an operation with nothing to report gives one result of
// kind nothing. Every result carries the status after the whole operation.
// The csr_ channel writes the window limit, the resend interval and the retry
// limit and is always ready; the user must write it only while the engine is
// idle, which the engine does not enforce. An operation is decoded in the
// cycle after acceptance. A simple operation goes from the decode state to
// the done state, which registers its final result. An ack reads and then
// releases each covered slot, a tick reads and checks each held slot for the
// timeout scan and then reads the slots again for the resend pass, and a
// shutdown reads each send slot and checks each receive slot, reading only
// the kept ones. The window memories have registered read ports and are
// visited one slot at a time. The next operation is accepted once the final
// result sits in the output register.
// Reset clears the status to invalid, empties both windows and restores the
// register defaults. A stalled receiver holds the sequencer at its next
// result; no result is lost.
// ============================================================================
`default_nettype none

module reliable_datagram_window #(
   parameter int SEND_DEPTH = rdw_pkg::SEND_DEPTH_DEF,
   parameter int RECV_DEPTH = rdw_pkg::RECV_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [3:0]  req_op,
   input  wire  [31:0] req_packet_id,
   input  wire  [15:0] req_handle,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_packet_id_res,
   output logic [15:0] rsp_handle_res,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_data
);

   rdw_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rdw_pkg::CSR_WINDOW_LIMIT: cfg_in.window_limit     = csr_data[4:0];
            rdw_pkg::CSR_RETX_IVAL:    cfg_in.retrans_interval = csr_data[15:0];
            rdw_pkg::CSR_RETRY_LIMIT:  cfg_in.retry_limit      = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_limit     <= rdw_pkg::WINDOW_LIMIT_RST;
         cfg_ff.retrans_interval <= rdw_pkg::RETX_IVAL_RST;
         cfg_ff.retry_limit      <= rdw_pkg::RETRY_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rdw_engine #(.SEND_DEPTH(SEND_DEPTH), .RECV_DEPTH(RECV_DEPTH)) u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_packet_id     (req_packet_id),
      .req_handle        (req_handle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_packet_id_res (rsp_packet_id_res),
      .rsp_handle_res    (rsp_handle_res),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // A result of kind nothing is always the only, and so the final, one.
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == rdw_pkg::K_NONE |-> rsp_last)
      else $error("result of kind nothing without last flag");

   // Resends only happen while established, possibly ending in shutdown.
   a_retx_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == rdw_pkg::K_RETX |->
         rsp_status == rdw_pkg::ST_ESTAB || rsp_status == rdw_pkg::ST_DISABLED)
      else $error("resend reported with unexpected status");

   // Delivery and acks leave the connection established.
   a_deliver_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rdw_pkg::K_DELIVER || rsp_kind == rdw_pkg::K_ACK)
         |-> rsp_status == rdw_pkg::ST_ESTAB)
      else $error("delivery or ack reported outside established status");

endmodule

`default_nettype wire

>>> sv/rdw_ram.sv
// ============================================================================
// rdw_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module rdw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire                                  clock,
   input  wire                                  wr_en,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                     wr_data,
   input  wire                                  rd_en,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/rdw_engine.sv
// ============================================================================
// rdw_engine
// Sequencer of the connection: walks the send and receive window memories
// and emits the result transactions of one input transaction at a time.
// ============================================================================
`default_nettype none

module rdw_engine #(
   parameter int SEND_DEPTH = rdw_pkg::SEND_DEPTH_DEF,
   parameter int RECV_DEPTH = rdw_pkg::RECV_DEPTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire rdw_pkg::cfg_type cfg,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [3:0]           req_op,
   input  wire  [31:0]          req_packet_id,
   input  wire  [15:0]          req_handle,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [2:0]           rsp_kind,
   output logic [31:0]          rsp_packet_id_res,
   output logic [15:0]          rsp_handle_res,
   output logic [2:0]           rsp_status,
   output logic                 rsp_last
);

   localparam int SA = SEND_DEPTH > 1 ? $clog2(SEND_DEPTH) : 1;
   localparam int RA = RECV_DEPTH > 1 ? $clog2(RECV_DEPTH) : 1;
   localparam int CW = $clog2(SEND_DEPTH + 1);
   localparam int MAXD = SEND_DEPTH > RECV_DEPTH ? SEND_DEPTH : RECV_DEPTH;
   localparam int IW = $clog2(MAXD + 1);
   localparam int SEND_W = $bits(rdw_pkg::send_entry_type);
   localparam int DPOS_OPEN = 1 % RECV_DEPTH;

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_ACK_RD   = 4'd2;
   localparam logic [3:0] S_ACK_EV   = 4'd3;
   localparam logic [3:0] S_DATA_REL = 4'd4;
   localparam logic [3:0] S_TAKE_EV  = 4'd5;
   localparam logic [3:0] S_SCAN_RD  = 4'd6;
   localparam logic [3:0] S_SCAN_EV  = 4'd7;
   localparam logic [3:0] S_RETX_RD  = 4'd8;
   localparam logic [3:0] S_RETX_EV  = 4'd9;
   localparam logic [3:0] S_SHS_RD   = 4'd10;
   localparam logic [3:0] S_SHS_EV   = 4'd11;
   localparam logic [3:0] S_SHR_CHK  = 4'd12;
   localparam logic [3:0] S_SHR_EV   = 4'd13;
   localparam logic [3:0] S_DONE     = 4'd14;

   // Position arithmetic on the circular windows.
   function automatic logic [SA-1:0] send_pos(input logic [SA-1:0] base,
                                              input logic [SA-1:0] ofs);
      logic [SA:0] s;
      s = {1'b0, base} + {1'b0, ofs};
      if (s >= (SA+1)'(SEND_DEPTH)) begin
         s = s - (SA+1)'(SEND_DEPTH);
      end
      return s[SA-1:0];
   endfunction

   function automatic logic [RA-1:0] recv_pos(input logic [RA-1:0] base,
                                              input logic [RA-1:0] ofs);
      logic [RA:0] s;
      s = {1'b0, base} + {1'b0, ofs};
      if (s >= (RA+1)'(RECV_DEPTH)) begin
         s = s - (RA+1)'(RECV_DEPTH);
      end
      return s[RA-1:0];
   endfunction

   logic [3:0]            state_ff, state_in;
   logic [3:0]            op_ff, op_in;
   logic [31:0]           pid_ff, pid_in;
   logic [15:0]           hnd_ff, hnd_in;
   logic [2:0]            status_ff, status_in;
   logic [31:0]           next_id_ff, next_id_in;
   logic [31:0]           deliv_ff, deliv_in;
   logic [RA-1:0]         dpos_ff, dpos_in;
   logic [31:0]           now_ff, now_in;
   logic [SA-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [RECV_DEPTH-1:0] rvalid_ff, rvalid_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         lim_ff, lim_in;
   logic                  tmo_ff, tmo_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [2:0]            pend_kind_ff, pend_kind_in;
   logic [31:0]           pend_id_ff, pend_id_in;
   logic [15:0]           pend_hnd_ff, pend_hnd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_kind_ff, rsp_kind_in;
   logic [31:0]           rsp_id_ff, rsp_id_in;
   logic [15:0]           rsp_hnd_ff, rsp_hnd_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                  s_wr_en, s_rd_en;
   logic [SA-1:0]         s_wr_addr, s_rd_addr;
   rdw_pkg::send_entry_type s_wr_data, s_rd_data;
   logic                  r_wr_en, r_rd_en;
   logic [RA-1:0]         r_wr_addr, r_rd_addr;
   logic [15:0]           r_wr_data, r_rd_data;

   // Working values.
   logic                  can_out, go_ok;
   logic                  em_req;
   logic [2:0]            em_kind;
   logic [31:0]           em_id;
   logic [15:0]           em_hnd;
   logic [4:0]            win_lim;
   logic [31:0]           off;
   logic [31:0]           diff;
   logic                  due;
   logic [SA-1:0]         spos;
   logic [RA-1:0]         rpos;

   rdw_ram #(.WIDTH(SEND_W), .DEPTH(SEND_DEPTH)) u_send_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   rdw_ram #(.WIDTH(16), .DEPTH(RECV_DEPTH)) u_recv_ram (
      .clock   (clock),
      .wr_en   (r_wr_en),
      .wr_addr (r_wr_addr),
      .wr_data (r_wr_data),
      .rd_en   (r_rd_en),
      .rd_addr (r_rd_addr),
      .rd_data (r_rd_data)
   );

   assign can_out = !rsp_valid_ff || rsp_ready;
   assign go_ok   = !pend_valid_ff || can_out;
   assign win_lim = (cfg.window_limit < 5'(SEND_DEPTH)) ? cfg.window_limit
                                                        : 5'(SEND_DEPTH);
   assign diff    = now_ff - s_rd_data.deadline;
   assign due     = !diff[31];
   assign off     = pid_ff - deliv_ff - 32'd1;

   // Sequencer and result staging.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pid_in        = pid_ff;
      hnd_in        = hnd_ff;
      status_in     = status_ff;
      next_id_in    = next_id_ff;
      deliv_in      = deliv_ff;
      dpos_in       = dpos_ff;
      now_in        = now_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rvalid_in     = rvalid_ff;
      idx_in        = idx_ff;
      lim_in        = lim_ff;
      tmo_in        = tmo_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;
      pend_hnd_in   = pend_hnd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_hnd_in    = rsp_hnd_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      s_wr_en       = 1'b0;
      s_wr_addr     = '0;
      s_wr_data     = s_rd_data;
      s_rd_en       = 1'b0;
      s_rd_addr     = '0;
      r_wr_en       = 1'b0;
      r_wr_addr     = '0;
      r_wr_data     = hnd_ff;
      r_rd_en       = 1'b0;
      r_rd_addr     = '0;
      em_req        = 1'b0;
      em_kind       = rdw_pkg::K_NONE;
      em_id         = '0;
      em_hnd        = '0;
      req_ready     = 1'b0;
      spos          = send_pos(head_ff, SA'(idx_ff));
      rpos          = recv_pos(dpos_ff, RA'(idx_ff));

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_op;
               pid_in   = req_packet_id;
               hnd_in   = req_handle;
               idx_in   = '0;
               tmo_in   = 1'b0;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_DONE;
            unique case (op_ff)
               rdw_pkg::OP_OPEN: begin
                  if (status_ff == rdw_pkg::ST_INVALID) begin
                     next_id_in = '0;
                     deliv_in   = '0;
                     dpos_in    = RA'(DPOS_OPEN);
                     status_in  = rdw_pkg::ST_ESTAB;
                  end else begin
                     status_in = rdw_pkg::ST_ERROR;
                  end
               end
               rdw_pkg::OP_SEND_REL: begin
                  if (status_ff != rdw_pkg::ST_ESTAB) begin
                     status_in = rdw_pkg::ST_ERROR;
                  end else begin
                     next_id_in = next_id_ff + 32'd1;
                     if (5'(count_ff) >= win_lim) begin
                        status_in = rdw_pkg::ST_ERROR;
                     end else begin
                        s_wr_en            = 1'b1;
                        s_wr_addr          = send_pos(head_ff, SA'(count_ff));
                        s_wr_data.id       = next_id_ff + 32'd1;
                        s_wr_data.handle   = hnd_ff;
                        s_wr_data.deadline = now_ff + 32'(cfg.retrans_interval);
                        s_wr_data.retries  = '0;
                        count_in           = count_ff + CW'(1);
                        em_req             = 1'b1;
                        em_kind            = rdw_pkg::K_TX;
                        em_id              = next_id_ff + 32'd1;
                        em_hnd             = hnd_ff;
                     end
                  end
               end
               rdw_pkg::OP_SEND_PLAIN: begin
                  if (status_ff != rdw_pkg::ST_ESTAB) begin
                     status_in = rdw_pkg::ST_ERROR;
                  end else begin
                     em_req  = 1'b1;
                     em_kind = rdw_pkg::K_TX;
                     em_hnd  = hnd_ff;
                  end
               end
               rdw_pkg::OP_ACK_IN: begin
                  if (pid_ff > next_id_ff) begin
                     status_in = rdw_pkg::ST_ERROR;
                  end else begin
                     state_in = S_ACK_RD;
                  end
               end
               rdw_pkg::OP_DATA_REL: begin
                  if (status_ff != rdw_pkg::ST_ESTAB) begin
                     status_in = rdw_pkg::ST_ERROR;
                  end else begin
                     em_req  = 1'b1;
                     em_kind = rdw_pkg::K_ACK;
                     em_id   = pid_ff;
                     rpos    = recv_pos(dpos_ff, off[RA-1:0]);
                     if (off < 32'(RECV_DEPTH) && !rvalid_ff[rpos]) begin
                        rvalid_in[rpos] = 1'b1;
                        r_wr_en         = 1'b1;
                        r_wr_addr       = rpos;
                     end else begin
                        state_in = S_DATA_REL;
                     end
                  end
               end
               rdw_pkg::OP_DATA_PLAIN: begin
                  if (status_ff != rdw_pkg::ST_ESTAB) begin
                     status_in = rdw_pkg::ST_ERROR;
                  end
               end
               rdw_pkg::OP_TAKE: begin
                  if (status_ff == rdw_pkg::ST_ESTAB && rvalid_ff[dpos_ff]) begin
                     r_rd_en   = 1'b1;
                     r_rd_addr = dpos_ff;
                     state_in  = S_TAKE_EV;
                  end
               end
               rdw_pkg::OP_TICK: begin
                  now_in = now_ff + 32'd1;
                  if (status_ff == rdw_pkg::ST_ESTAB) begin
                     if (count_ff != '0) begin
                        state_in = S_SCAN_RD;
                     end
                  end else if (status_ff == rdw_pkg::ST_TIMEOUT ||
                               status_ff == rdw_pkg::ST_CLOSING ||
                               status_ff == rdw_pkg::ST_ERROR) begin
                     status_in = rdw_pkg::ST_DISABLED;
                     state_in  = S_SHS_RD;
                  end
               end
               rdw_pkg::OP_SET_TMO: begin
                  if (status_ff == rdw_pkg::ST_ESTAB) begin
                     status_in = rdw_pkg::ST_TIMEOUT;
                  end
               end
               rdw_pkg::OP_SET_CLOSE: begin
                  if (status_ff == rdw_pkg::ST_ESTAB) begin
                     status_in = rdw_pkg::ST_CLOSING;
                  end
               end
               default: begin
               end
            endcase
         end

         // Cumulative ack: release from the oldest slot while its id is covered.
         S_ACK_RD: begin
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               s_rd_en   = 1'b1;
               s_rd_addr = head_ff;
               state_in  = S_ACK_EV;
            end
         end

         S_ACK_EV: begin
            if (s_rd_data.id <= pid_ff) begin
               em_req  = 1'b1;
               em_kind = rdw_pkg::K_RELEASE;
               em_id   = s_rd_data.id;
               em_hnd  = s_rd_data.handle;
               if (go_ok) begin
                  head_in  = send_pos(head_ff, SA'(1));
                  count_in = count_ff - CW'(1);
                  state_in = S_ACK_RD;
               end
            end else begin
               state_in = S_DONE;
            end
         end

         // Dropped reliable data: hand the handle back.
         S_DATA_REL: begin
            em_req  = 1'b1;
            em_kind = rdw_pkg::K_RELEASE;
            em_id   = pid_ff;
            em_hnd  = hnd_ff;
            if (go_ok) begin
               state_in = S_DONE;
            end
         end

         S_TAKE_EV: begin
            em_req  = 1'b1;
            em_kind = rdw_pkg::K_DELIVER;
            em_id   = deliv_ff + 32'd1;
            em_hnd  = r_rd_data;
            if (go_ok) begin
               rvalid_in[dpos_ff] = 1'b0;
               deliv_in           = deliv_ff + 32'd1;
               dpos_in            = recv_pos(dpos_ff, RA'(1));
               state_in           = S_DONE;
            end
         end

         // First pass of a tick: find whether a due slot has run out of retries.
         S_SCAN_RD: begin
            s_rd_en   = 1'b1;
            s_rd_addr = spos;
            state_in  = S_SCAN_EV;
         end

         S_SCAN_EV: begin
            if (due && s_rd_data.retries >= cfg.retry_limit) begin
               tmo_in    = 1'b1;
               lim_in    = CW'(idx_ff);
               status_in = rdw_pkg::ST_DISABLED;
               idx_in    = '0;
               state_in  = S_RETX_RD;
            end else if (idx_ff + IW'(1) == IW'(count_ff)) begin
               lim_in   = count_ff;
               idx_in   = '0;
               state_in = S_RETX_RD;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_SCAN_RD;
            end
         end

         // Second pass: resend due slots ahead of any exhausted one.
         S_RETX_RD: begin
            if (idx_ff == IW'(lim_ff)) begin
               idx_in   = '0;
               state_in = tmo_ff ? S_SHS_RD : S_DONE;
            end else begin
               s_rd_en   = 1'b1;
               s_rd_addr = spos;
               state_in  = S_RETX_EV;
            end
         end

         S_RETX_EV: begin
            if (due) begin
               em_req  = 1'b1;
               em_kind = rdw_pkg::K_RETX;
               em_id   = s_rd_data.id;
               em_hnd  = s_rd_data.handle;
               if (go_ok) begin
                  s_wr_en            = 1'b1;
                  s_wr_addr          = spos;
                  s_wr_data.retries  = s_rd_data.retries + 16'd1;
                  s_wr_data.deadline = now_ff + 32'(cfg.retrans_interval);
                  idx_in             = idx_ff + IW'(1);
                  state_in           = S_RETX_RD;
               end
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_RETX_RD;
            end
         end

         // Shutdown: release every held send slot, oldest first.
         S_SHS_RD: begin
            if (idx_ff == IW'(count_ff)) begin
               count_in = '0;
               head_in  = '0;
               idx_in   = '0;
               state_in = S_SHR_CHK;
            end else begin
               s_rd_en   = 1'b1;
               s_rd_addr = spos;
               state_in  = S_SHS_EV;
            end
         end

         S_SHS_EV: begin
            em_req  = 1'b1;
            em_kind = rdw_pkg::K_RELEASE;
            em_id   = s_rd_data.id;
            em_hnd  = s_rd_data.handle;
            if (go_ok) begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_SHS_RD;
            end
         end

         // Shutdown: release every kept received packet in id order.
         S_SHR_CHK: begin
            if (idx_ff == IW'(RECV_DEPTH)) begin
               state_in = S_DONE;
            end else if (rvalid_ff[rpos]) begin
               r_rd_en   = 1'b1;
               r_rd_addr = rpos;
               state_in  = S_SHR_EV;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end

         S_SHR_EV: begin
            em_req  = 1'b1;
            em_kind = rdw_pkg::K_RELEASE;
            em_id   = deliv_ff + 32'd1 + 32'(idx_ff);
            em_hnd  = r_rd_data;
            if (go_ok) begin
               rvalid_in[rpos] = 1'b0;
               idx_in          = idx_ff + IW'(1);
               state_in        = S_SHR_CHK;
            end
         end

         // Final result of the transaction carries the last flag.
         S_DONE: begin
            if (can_out) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pend_valid_ff ? pend_kind_ff : rdw_pkg::K_NONE;
               rsp_id_in     = pend_valid_ff ? pend_id_ff : '0;
               rsp_hnd_in    = pend_valid_ff ? pend_hnd_ff : '0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A new result moves the held one to the output register.
      if (em_req && go_ok) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = pend_kind_ff;
            rsp_id_in     = pend_id_ff;
            rsp_hnd_in    = pend_hnd_ff;
            rsp_status_in = status_ff;
            rsp_last_in   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_kind_in  = em_kind;
         pend_id_in    = em_id;
         pend_hnd_in   = em_hnd;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         status_ff     <= rdw_pkg::ST_INVALID;
         next_id_ff    <= '0;
         deliv_ff      <= '0;
         dpos_ff       <= RA'(DPOS_OPEN);
         now_ff        <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         rvalid_ff     <= '0;
         tmo_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         status_ff     <= status_in;
         next_id_ff    <= next_id_in;
         deliv_ff      <= deliv_in;
         dpos_ff       <= dpos_in;
         now_ff        <= now_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rvalid_ff     <= rvalid_in;
         tmo_ff        <= tmo_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      hnd_ff        <= hnd_in;
      idx_ff        <= idx_in;
      lim_ff        <= lim_in;
      pend_kind_ff  <= pend_kind_in;
      pend_id_ff    <= pend_id_in;
      pend_hnd_ff   <= pend_hnd_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_hnd_ff    <= rsp_hnd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_packet_id_res = rsp_id_ff;
   assign rsp_handle_res    = rsp_hnd_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking testbench of the reliable datagram window engine. A queue
// of operations feeds a clocked driver; a clocked monitor compares every
// result transaction with the output of a behavioural predictor.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

   localparam int QUIET_LIMIT = 20000;
   localparam int SETTLE      = 200;
   localparam int BACKLOG_MAX = 2048;
   localparam int OWED_MAX    = 16384;
   localparam int STEP_MAX    = 64;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] pid;
      logic [15:0] hnd;
   } op_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] pid;
      logic [15:0] hnd;
      logic [2:0]  status;
      logic        last;
   } result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_op;
   logic [31:0] req_packet_id;
   logic [15:0] req_handle;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_packet_id_res;
   logic [15:0] rsp_handle_res;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   reliable_datagram_window dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_packet_id(req_packet_id), .req_handle(req_handle),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_packet_id_res(rsp_packet_id_res), .rsp_handle_res(rsp_handle_res),
      .rsp_status(rsp_status), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Operations waiting to be offered and results still owed by the engine,
   // each kept as a ring with read and write counts.
   op_item_type backlog_mem[BACKLOG_MAX];
   int          backlog_rd;
   int          backlog_wr;
   result_type  owed_mem[OWED_MAX];
   int          owed_rd;
   int          owed_wr;
   result_type  step_mem[STEP_MAX];
   int          step_n;

   int  bad_count;
   int  ops_taken;
   int  cyc;
   int  quiet;
   int  hold_left;
   bit  held_once;
   bit  req_went;

   // Predicted connection state.
   logic [4:0]  p_wlim;
   logic [15:0] p_ival;
   logic [15:0] p_rlim;
   logic [2:0]  p_status;
   logic [31:0] p_next;
   logic [31:0] p_deliv;
   logic [31:0] p_now;
   logic [31:0] s_id[16];
   logic [15:0] s_hnd[16];
   logic [31:0] s_dl[16];
   logic [15:0] s_rt[16];
   int          s_head;
   int          s_count;
   bit          r_have[16];
   logic [15:0] r_hnd[16];

   function automatic void put(logic [2:0] k, logic [31:0] id, logic [15:0] h);
      result_type r;
      r = '0;
      r.kind = k;
      r.pid = id;
      r.hnd = h;
      if (step_n < STEP_MAX) begin
         step_mem[step_n] = r;
         step_n++;
      end
   endfunction

   function automatic int window_cap();
      return (p_wlim > 5'd16) ? 16 : int'(p_wlim);
   endfunction

   // Release everything held on both sides and disable the connection.
   function automatic void shut_connection();
      int p;
      logic [31:0] id;
      p_status = rdw_pkg::ST_DISABLED;
      for (int i = 0; i < s_count; i++) begin
         p = (s_head + i) % 16;
         put(rdw_pkg::K_RELEASE, s_id[p], s_hnd[p]);
      end
      s_count = 0;
      s_head = 0;
      for (int i = 0; i < 16; i++) begin
         id = p_deliv + 32'd1 + 32'(i);
         if (r_have[id[3:0]]) begin
            put(rdw_pkg::K_RELEASE, id, r_hnd[id[3:0]]);
            r_have[id[3:0]] = 0;
         end
      end
   endfunction

   // Works out the results of one operation and queues them as owed.
   function automatic void predict_op(op_item_type it);
      int p;
      logic [31:0] off;
      logic [31:0] diff;
      logic [31:0] id;
      result_type r;
      step_n = 0;
      case (it.op)
         rdw_pkg::OP_OPEN: begin
            if (p_status == rdw_pkg::ST_INVALID) begin
               p_next = 0;
               p_deliv = 0;
               p_status = rdw_pkg::ST_ESTAB;
            end else p_status = rdw_pkg::ST_ERROR;
         end
         rdw_pkg::OP_SEND_REL: begin
            if (p_status != rdw_pkg::ST_ESTAB) p_status = rdw_pkg::ST_ERROR;
            else begin
               p_next = p_next + 32'd1;
               if (s_count >= window_cap()) p_status = rdw_pkg::ST_ERROR;
               else begin
                  p = (s_head + s_count) % 16;
                  s_id[p] = p_next;
                  s_hnd[p] = it.hnd;
                  s_dl[p] = p_now + 32'(p_ival);
                  s_rt[p] = 0;
                  s_count++;
                  put(rdw_pkg::K_TX, p_next, it.hnd);
               end
            end
         end
         rdw_pkg::OP_SEND_PLAIN: begin
            if (p_status != rdw_pkg::ST_ESTAB) p_status = rdw_pkg::ST_ERROR;
            else put(rdw_pkg::K_TX, 32'd0, it.hnd);
         end
         rdw_pkg::OP_ACK_IN: begin
            if (it.pid > p_next) p_status = rdw_pkg::ST_ERROR;
            else begin
               while (s_count > 0 && s_id[s_head] <= it.pid) begin
                  put(rdw_pkg::K_RELEASE, s_id[s_head], s_hnd[s_head]);
                  s_head = (s_head + 1) % 16;
                  s_count--;
               end
            end
         end
         rdw_pkg::OP_DATA_REL: begin
            if (p_status != rdw_pkg::ST_ESTAB) p_status = rdw_pkg::ST_ERROR;
            else begin
               put(rdw_pkg::K_ACK, it.pid, 16'd0);
               off = it.pid - p_deliv - 32'd1;
               if (off < 32'd16 && !r_have[it.pid[3:0]]) begin
                  r_have[it.pid[3:0]] = 1;
                  r_hnd[it.pid[3:0]] = it.hnd;
               end else put(rdw_pkg::K_RELEASE, it.pid, it.hnd);
            end
         end
         rdw_pkg::OP_DATA_PLAIN: begin
            if (p_status != rdw_pkg::ST_ESTAB) p_status = rdw_pkg::ST_ERROR;
         end
         rdw_pkg::OP_TAKE: begin
            id = p_deliv + 32'd1;
            if (p_status == rdw_pkg::ST_ESTAB && r_have[id[3:0]]) begin
               r_have[id[3:0]] = 0;
               p_deliv = id;
               put(rdw_pkg::K_DELIVER, id, r_hnd[id[3:0]]);
            end
         end
         rdw_pkg::OP_TICK: begin
            p_now = p_now + 32'd1;
            if (p_status == rdw_pkg::ST_ESTAB) begin
               for (int i = 0; i < s_count; i++) begin
                  p = (s_head + i) % 16;
                  diff = p_now - s_dl[p];
                  if (!diff[31]) begin
                     if (s_rt[p] >= p_rlim) begin
                        p_status = rdw_pkg::ST_TIMEOUT;
                        break;
                     end
                     s_rt[p] = s_rt[p] + 16'd1;
                     s_dl[p] = p_now + 32'(p_ival);
                     put(rdw_pkg::K_RETX, s_id[p], s_hnd[p]);
                  end
               end
            end
            if (p_status == rdw_pkg::ST_TIMEOUT || p_status == rdw_pkg::ST_CLOSING ||
                p_status == rdw_pkg::ST_ERROR)
               shut_connection();
         end
         rdw_pkg::OP_SET_TMO:
            if (p_status == rdw_pkg::ST_ESTAB) p_status = rdw_pkg::ST_TIMEOUT;
         rdw_pkg::OP_SET_CLOSE:
            if (p_status == rdw_pkg::ST_ESTAB) p_status = rdw_pkg::ST_CLOSING;
         default: ;
      endcase
      if (step_n == 0) put(rdw_pkg::K_NONE, 32'd0, 16'd0);
      for (int k = 0; k < step_n; k++) begin
         r = step_mem[k];
         r.status = p_status;
         r.last = (k == step_n - 1);
         owed_mem[owed_wr % OWED_MAX] = r;
         owed_wr++;
      end
   endfunction

   function automatic void note_bad(string what, result_type want, result_type got);
      if (bad_count < 10)
         $display("mismatch %s: expected k%0d id%h h%h s%0d l%0d got k%0d id%h h%h s%0d l%0d",
                  what, want.kind, want.pid, want.hnd, want.status, want.last,
                  got.kind, got.pid, got.hnd, got.status, got.last);
      bad_count++;
   endfunction

   function automatic bit idle_now();
      if (cyc >= 800 && cyc < 2000) return 0;
      return $urandom_range(0, 99) < 29;
   endfunction

   // Clock.
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Input side: accept on the rising edge, drive on the falling edge.
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (!reset && req_valid && req_ready) begin
         predict_op(backlog_mem[backlog_rd % BACKLOG_MAX]);
         backlog_rd++;
         ops_taken++;
         req_went = 1;
      end
   end

   always @(negedge clock) begin
      if (!req_valid || req_went) begin
         req_went = 0;
         if (!reset && backlog_wr != backlog_rd && !idle_now()) begin
            req_valid <= 1;
            req_op <= backlog_mem[backlog_rd % BACKLOG_MAX].op;
            req_packet_id <= backlog_mem[backlog_rd % BACKLOG_MAX].pid;
            req_handle <= backlog_mem[backlog_rd % BACKLOG_MAX].hnd;
         end else req_valid <= 0;
      end
   end

   // Result side, with one long hold-off to back the engine up.
   always @(negedge clock) begin
      if (!held_once && ops_taken >= 150) begin
         held_once = 1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else rsp_ready <= !reset && !idle_now();
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_kind, rsp_packet_id_res, rsp_handle_res, rsp_status, rsp_last};
         if (owed_wr == owed_rd) note_bad("unexpected", '0, got);
         else begin
            want = owed_mem[owed_rd % OWED_MAX];
            owed_rd++;
            if (got !== want) note_bad("field", want, got);
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) quiet <= 0;
      else if (quiet >= QUIET_LIMIT) begin
         $display("FAIL reliable_datagram_window");
         $finish;
      end else quiet <= quiet + 1;
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         rdw_pkg::CSR_WINDOW_LIMIT: p_wlim = val[4:0];
         rdw_pkg::CSR_RETX_IVAL: p_ival = val[15:0];
         rdw_pkg::CSR_RETRY_LIMIT: p_rlim = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic settings(int wl, int iv, int rl);
      write_reg(rdw_pkg::CSR_WINDOW_LIMIT, 32'(wl));
      write_reg(rdw_pkg::CSR_RETX_IVAL, 32'(iv));
      write_reg(rdw_pkg::CSR_RETRY_LIMIT, 32'(rl));
   endtask

   task automatic offer(logic [3:0] op, logic [31:0] pid, logic [15:0] hnd);
      op_item_type it;
      it.op = op;
      it.pid = pid;
      it.hnd = hnd;
      backlog_mem[backlog_wr % BACKLOG_MAX] = it;
      backlog_wr++;
   endtask

   // Sender pause: wait until every owed result has come back.
   task automatic drain();
      while (backlog_wr != backlog_rd || req_valid || owed_wr != owed_rd)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // A batch of operations that keep the connection established.
   task automatic live_batch(int n);
      int r;
      int sends;
      int back;
      logic [31:0] id;
      sends = 0;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 22) begin
            if (s_count + sends < window_cap()) begin
               offer(rdw_pkg::OP_SEND_REL, $urandom(), 16'($urandom()));
               sends++;
            end else offer(rdw_pkg::OP_TICK, $urandom(), 16'($urandom()));
         end else if (r < 30)
            offer(rdw_pkg::OP_SEND_PLAIN, $urandom(), 16'($urandom()));
         else if (r < 45) begin
            back = $urandom_range(0, 20);
            id = (32'(back) > p_next) ? 32'd0 : p_next - 32'(back);
            offer(rdw_pkg::OP_ACK_IN, id, 16'($urandom()));
         end else if (r < 70) begin
            if ($urandom_range(0, 9) == 0) id = $urandom();
            else id = p_deliv + 32'($urandom_range(1, 16));
            offer(rdw_pkg::OP_DATA_REL, id, 16'($urandom()));
         end else if (r < 75)
            offer(rdw_pkg::OP_DATA_PLAIN, $urandom(), 16'($urandom()));
         else if (r < 88) offer(rdw_pkg::OP_TAKE, $urandom(), 16'($urandom()));
         else if (r < 97) offer(rdw_pkg::OP_TICK, $urandom(), 16'($urandom()));
         else offer(4'($urandom_range(10, 15)), $urandom(), 16'($urandom()));
      end
      drain();
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_op = 0;
      req_packet_id = 0;
      req_handle = 0;
      rsp_ready = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      backlog_rd = 0;
      backlog_wr = 0;
      owed_rd = 0;
      owed_wr = 0;
      step_n = 0;
      bad_count = 0;
      ops_taken = 0;
      cyc = 0;
      quiet = 0;
      hold_left = 0;
      held_once = 0;
      req_went = 0;
      p_wlim = rdw_pkg::WINDOW_LIMIT_RST;
      p_ival = rdw_pkg::RETX_IVAL_RST;
      p_rlim = rdw_pkg::RETRY_LIMIT_RST;
      p_status = rdw_pkg::ST_INVALID;
      p_next = 0;
      p_deliv = 0;
      p_now = 0;
      s_head = 0;
      s_count = 0;
      for (int i = 0; i < 16; i++) r_have[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed opening: window edges, duplicates, extremes of the fields.
      offer(rdw_pkg::OP_OPEN, 32'd0, 16'd0);
      offer(rdw_pkg::OP_SEND_REL, 32'hFFFFFFFF, 16'h0000);
      offer(rdw_pkg::OP_SEND_REL, 32'd0, 16'hFFFF);
      offer(rdw_pkg::OP_SEND_PLAIN, 32'd0, 16'hA5A5);
      offer(rdw_pkg::OP_DATA_REL, 32'd1, 16'h1111);
      offer(rdw_pkg::OP_DATA_REL, 32'd0, 16'h2222);
      offer(rdw_pkg::OP_DATA_REL, 32'hFFFFFFFF, 16'hFFFF);
      offer(rdw_pkg::OP_DATA_REL, 32'd1, 16'h3333);
      offer(rdw_pkg::OP_DATA_REL, 32'd17, 16'h4444);
      offer(rdw_pkg::OP_DATA_REL, 32'd16, 16'h5555);
      offer(rdw_pkg::OP_DATA_PLAIN, 32'h5A5A5A5A, 16'h6666);
      offer(rdw_pkg::OP_TAKE, 32'd0, 16'd0);
      offer(rdw_pkg::OP_TAKE, 32'd0, 16'd0);
      offer(rdw_pkg::OP_ACK_IN, 32'd0, 16'd0);
      offer(rdw_pkg::OP_ACK_IN, 32'd1, 16'd0);
      offer(rdw_pkg::OP_TICK, 32'd0, 16'd0);
      offer(4'd15, 32'hFFFFFFFF, 16'hFFFF);
      offer(4'd10, 32'd0, 16'd0);
      drain();

      // Random phases under several settings, the connection kept alive.
      settings(4, 1, 65535);
      live_batch(80);
      settings(1, 65535, 65535);
      live_batch(80);
      settings(16, 3, 65535);
      live_batch(80);
      settings(8, 1, 1000);
      live_batch(80);
      settings(16, 50, 65535);
      live_batch(80);
      settings(12, 2, 40000);
      live_batch(80);

      // Retry limit of zero: the next due packet times the connection out.
      settings(2, 1, 0);
      offer(rdw_pkg::OP_ACK_IN, p_next, 16'd0);
      offer(rdw_pkg::OP_SEND_REL, 32'd0, 16'hBEEF);
      offer(rdw_pkg::OP_DATA_REL, p_deliv + 32'd2, 16'hCAFE);
      offer(rdw_pkg::OP_TICK, 32'd0, 16'd0);
      offer(rdw_pkg::OP_TICK, 32'd0, 16'd0);
      drain();

      // The connection is dead: every operation is now an error or ignored.
      offer(rdw_pkg::OP_OPEN, 32'd0, 16'd0);
      offer(rdw_pkg::OP_TICK, 32'd0, 16'd0);
      offer(rdw_pkg::OP_ACK_IN, 32'hFFFFFFFF, 16'd0);
      offer(rdw_pkg::OP_SET_TMO, 32'd0, 16'd0);
      offer(rdw_pkg::OP_SET_CLOSE, 32'd0, 16'd0);
      for (int i = 0; i < 20; i++)
         offer(4'($urandom_range(0, 15)), $urandom(), 16'($urandom()));
      drain();

      repeat (SETTLE) @(posedge clock);
      if (bad_count == 0 && owed_wr == owed_rd)
         $display("PASS reliable_datagram_window");
      else
         $display("FAIL reliable_datagram_window");
      $finish;
   end

endmodule
